[design/ndpad_pkg.sv]
// ----------------------------------------------------------------------------
// ndpad_pkg: shared types and constants of the padding address generator
// Register indexes, padding modes, state codes and the structs that travel
// between the register file, the top level and the per-dimension unit.
// ----------------------------------------------------------------------------
package ndpad_pkg;

  // Register indexes (byte address is 8 * index)
  localparam logic [2:0] REG_PAD_MODE    = 3'd0;
  localparam logic [2:0] REG_DIMS_IN_USE = 3'd1;
  localparam logic [2:0] REG_IN_SIZES    = 3'd2;
  localparam logic [2:0] REG_PAD_BEFORE  = 3'd3;
  localparam logic [2:0] REG_PAD_AFTER   = 3'd4;
  localparam logic [2:0] REG_IN_STRIDES  = 3'd5;
  localparam logic [2:0] REG_OUT_STRIDES = 3'd6;
  localparam logic [2:0] REG_PAD_FILL    = 3'd7;

  localparam int OFS_BITS = 34;

  typedef enum logic [1:0] {
    PM_CONST     = 2'd0,
    PM_REFLECT   = 2'd1,
    PM_REPLICATE = 2'd2,
    PM_CIRCULAR  = 2'd3
  } pad_mode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_OUT
  } top_state_t;

  typedef enum logic [2:0] {
    U_IDLE,
    U_MODSET,
    U_DIV,
    U_FOLD,
    U_MAC,
    U_DONE
  } unit_state_t;

  // Register file contents
  typedef struct packed {
    pad_mode_t   mode;
    logic [2:0]  dims;
    logic [63:0] in_sizes;
    logic [63:0] pad_before;
    logic [63:0] pad_after;
    logic [63:0] in_strides;
    logic [63:0] out_strides;
    logic [63:0] pad_fill;
  } cfg_t;

  // Per-dimension settings handed to the dimension unit
  typedef struct packed {
    pad_mode_t   mode;
    logic [15:0] in_size;
    logic [15:0] pad_b;
    logic [15:0] pad_a;
    logic [15:0] in_stride;
    logic [15:0] out_stride;
  } dim_cfg_t;

  // Per-dimension result returned by the dimension unit
  typedef struct packed {
    logic                done;
    logic                fill;
    logic                at_end;
    logic [OFS_BITS-1:0] oprod;
    logic [OFS_BITS-1:0] iprod;
  } dim_res_t;

  // 16-bit field of a packed register; dimensions 4 and up read as zero
  function automatic logic [15:0] field16(input logic [63:0] r, input logic [3:0] d);
    logic [15:0] f;
    f = '0;
    if (d < 4'd4) begin
      f = r[{d[1:0], 4'b0000} +: 16];
    end
    return f;
  endfunction

endpackage

[design/ndpad_cfg_regs.sv]
// ----------------------------------------------------------------------------
// ndpad_cfg_regs: configuration register file
// APB-style slave with 64-bit registers at byte addresses 8 * index; writes
// complete in the access phase, reads return the stored value.
// ----------------------------------------------------------------------------
module ndpad_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  output ndpad_pkg::cfg_t    cfg
);
  import ndpad_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[5:3];
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  // Write registers on a completed write transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode        <= PM_CONST;
      cfg_r.dims        <= 3'd1;
      cfg_r.in_sizes    <= '0;
      cfg_r.pad_before  <= '0;
      cfg_r.pad_after   <= '0;
      cfg_r.in_strides  <= '0;
      cfg_r.out_strides <= '0;
      cfg_r.pad_fill    <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_PAD_MODE:    cfg_r.mode        <= pad_mode_t'(pwdata[1:0]);
        REG_DIMS_IN_USE: cfg_r.dims        <= pwdata[2:0];
        REG_IN_SIZES:    cfg_r.in_sizes    <= pwdata;
        REG_PAD_BEFORE:  cfg_r.pad_before  <= pwdata;
        REG_PAD_AFTER:   cfg_r.pad_after   <= pwdata;
        REG_IN_STRIDES:  cfg_r.in_strides  <= pwdata;
        REG_OUT_STRIDES: cfg_r.out_strides <= pwdata;
        REG_PAD_FILL:    cfg_r.pad_fill    <= pwdata;
        default:         cfg_r.pad_fill    <= cfg_r.pad_fill;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      REG_PAD_MODE:    prdata = {62'd0, cfg_r.mode};
      REG_DIMS_IN_USE: prdata = {61'd0, cfg_r.dims};
      REG_IN_SIZES:    prdata = cfg_r.in_sizes;
      REG_PAD_BEFORE:  prdata = cfg_r.pad_before;
      REG_PAD_AFTER:   prdata = cfg_r.pad_after;
      REG_IN_STRIDES:  prdata = cfg_r.in_strides;
      REG_OUT_STRIDES: prdata = cfg_r.out_strides;
      REG_PAD_FILL:    prdata = cfg_r.pad_fill;
      default:         prdata = '0;
    endcase
  end

endmodule

[design/ndpad_dim_unit.sv]
// ----------------------------------------------------------------------------
// ndpad_dim_unit: shared per-dimension map, fold and multiply unit
// Maps one output coordinate to its source coordinate (constant, reflect,
// replicate, circular), with a bit-serial remainder for large pads, then
// forms both stride products. Reused for every dimension of an element.
// ----------------------------------------------------------------------------
module ndpad_dim_unit #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [COORD_BITS-1:0] coord,
  input  ndpad_pkg::dim_cfg_t   dcfg,
  output ndpad_pkg::dim_res_t   res
);
  import ndpad_pkg::*;

  localparam int MW  = (COORD_BITS > 16) ? COORD_BITS : 16;  // magnitude bits
  localparam int IW  = MW + 1;                                // signed index bits
  localparam int KW  = MW + 1;                                // period compare bits
  localparam int EW  = (COORD_BITS + 1 > 18) ? COORD_BITS + 1 : 18;
  localparam int CW  = $clog2(MW);

  unit_state_t           state_r, state_nxt;
  logic [COORD_BITS-1:0] c_r, c_nxt;
  logic [15:0]           os_r, os_nxt, is_r, is_nxt, n_r, n_nxt, src_r, src_nxt;
  pad_mode_t             mode_r, mode_nxt;
  logic [IW-1:0]         i_r, i_nxt;
  logic                  fill_r, fill_nxt, end_r, end_nxt, neg_r, neg_nxt;
  logic [16:0]           div_r, div_nxt;
  logic [17:0]           rem_r, rem_nxt;
  logic [MW-1:0]         mag_r, mag_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [OFS_BITS-1:0]   oprod_r, oprod_nxt, iprod_r, iprod_nxt;

  logic [IW-1:0]   i_w;
  logic            neg_w, inr_w;
  logic [17:0]     ext_raw;
  logic [EW-1:0]   ext, ext_lim, em1;
  logic [MW-1:0]   mag_w;
  logic [16:0]     div_w;
  logic [17:0]     shift_w;
  logic [16:0]     r0_w, r1_w;
  logic [47:0]     omul_w;
  logic [31:0]     imul_w;

  // Index relative to the input, extent and end-of-dimension test
  always_comb begin
    i_w     = IW'(coord) - IW'(dcfg.pad_b);
    neg_w   = i_w[IW-1];
    inr_w   = !neg_w && (i_w < IW'(dcfg.in_size));
    ext_raw = 18'(dcfg.in_size) + 18'(dcfg.pad_b) + 18'(dcfg.pad_a);
    ext_lim = EW'(1) << COORD_BITS;
    ext     = EW'(ext_raw);
    if (ext > ext_lim) begin
      ext = ext_lim;
    end
    if (ext == '0) begin
      ext = EW'(1);
    end
    em1 = ext - EW'(1);
  end

  // Remainder datapath pieces
  always_comb begin
    mag_w   = neg_r ? MW'(~i_r + IW'(1)) : MW'(i_r);
    div_w   = (mode_r == PM_REFLECT) ? ({n_r, 1'b0} - 17'd2) : {1'b0, n_r};
    shift_w = {rem_r[16:0], mag_r[MW-1]};
    r0_w    = (neg_r && (rem_r[16:0] != '0)) ? (div_r - rem_r[16:0]) : rem_r[16:0];
    r1_w    = ((mode_r == PM_REFLECT) && (r0_w >= {1'b0, n_r})) ? (div_r - r0_w) : r0_w;
    omul_w  = 32'(c_r) * os_r;
    imul_w  = src_r * is_r;
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    c_nxt     = c_r;
    os_nxt    = os_r;
    is_nxt    = is_r;
    n_nxt     = n_r;
    src_nxt   = src_r;
    mode_nxt  = mode_r;
    i_nxt     = i_r;
    fill_nxt  = fill_r;
    end_nxt   = end_r;
    neg_nxt   = neg_r;
    div_nxt   = div_r;
    rem_nxt   = rem_r;
    mag_nxt   = mag_r;
    cnt_nxt   = cnt_r;
    oprod_nxt = oprod_r;
    iprod_nxt = iprod_r;

    unique case (state_r)
      U_IDLE, U_DONE: begin
        state_nxt = U_IDLE;
        if (start) begin
          // Latch operands and resolve the easy cases at once
          c_nxt     = coord;
          os_nxt    = dcfg.out_stride;
          is_nxt    = dcfg.in_stride;
          n_nxt     = dcfg.in_size;
          mode_nxt  = dcfg.mode;
          i_nxt     = i_w;
          neg_nxt   = neg_w;
          end_nxt   = EW'(coord) >= em1;
          fill_nxt  = 1'b0;
          src_nxt   = '0;
          state_nxt = U_MAC;
          if (dcfg.in_size == '0) begin
            fill_nxt = 1'b1;
          end else if (inr_w) begin
            src_nxt = i_w[15:0];
          end else begin
            unique case (dcfg.mode)
              PM_CONST:     fill_nxt = 1'b1;
              PM_REPLICATE: src_nxt  = neg_w ? 16'd0 : (dcfg.in_size - 16'd1);
              PM_REFLECT: begin
                if (dcfg.in_size != 16'd1) begin
                  state_nxt = U_MODSET;
                end
              end
              PM_CIRCULAR:  state_nxt = U_MODSET;
              default:      fill_nxt  = 1'b1;
            endcase
          end
        end
      end
      U_MODSET: begin
        // Skip the serial remainder when the magnitude is already below the period
        div_nxt = div_w;
        if (KW'(mag_w) < KW'(div_w)) begin
          rem_nxt   = 18'(mag_w);
          state_nxt = U_FOLD;
        end else begin
          mag_nxt   = mag_w;
          rem_nxt   = '0;
          cnt_nxt   = CW'(MW - 1);
          state_nxt = U_DIV;
        end
      end
      U_DIV: begin
        // One restoring step per cycle, dividend bits MSB first
        rem_nxt = (shift_w >= {1'b0, div_r}) ? (shift_w - {1'b0, div_r}) : shift_w;
        mag_nxt = mag_r << 1;
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          state_nxt = U_FOLD;
        end
      end
      U_FOLD: begin
        src_nxt   = r1_w[15:0];
        state_nxt = U_MAC;
      end
      U_MAC: begin
        oprod_nxt = omul_w[OFS_BITS-1:0];
        iprod_nxt = fill_r ? '0 : OFS_BITS'(imul_w);
        state_nxt = U_DONE;
      end
      default: state_nxt = U_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    c_r     <= c_nxt;
    os_r    <= os_nxt;
    is_r    <= is_nxt;
    n_r     <= n_nxt;
    src_r   <= src_nxt;
    mode_r  <= mode_nxt;
    i_r     <= i_nxt;
    fill_r  <= fill_nxt;
    end_r   <= end_nxt;
    neg_r   <= neg_nxt;
    div_r   <= div_nxt;
    rem_r   <= rem_nxt;
    mag_r   <= mag_nxt;
    cnt_r   <= cnt_nxt;
    oprod_r <= oprod_nxt;
    iprod_r <= iprod_nxt;
  end

  assign res.done   = (state_r == U_DONE);
  assign res.fill   = fill_r;
  assign res.at_end = end_r;
  assign res.oprod  = oprod_r;
  assign res.iprod  = iprod_r;

endmodule

[design/nd_pad_address_generator.sv]
// ----------------------------------------------------------------------------
// nd_pad_address_generator: N-dimensional padding address generator
// Each transfer on the input yields one output element's offsets, walking the
// output coordinates in row-major order; one shared dimension unit serves
// every dimension in turn, from the fastest dimension back to dimension 0.
// Per element, each dimension in use passes through the unit's multiply and
//   done states; reflect or circular out of range adds the modulus set-up and
//   fold states, plus max(COORD_BITS,16) remainder steps when the distance
//   reaches the fold period.
// A new input is taken only after the element is loaded into the output register.
// Reset (synchronous, rst_n low): coordinates zero, registers to defaults.
// ----------------------------------------------------------------------------
module nd_pad_address_generator #(
  parameter int MAX_DIMS   = 4,
  parameter int COORD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_restart,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [33:0] out_out_offset,
  output logic [33:0] out_in_offset,
  output logic        out_use_fill,
  output logic [63:0] out_fill_word,
  output logic        out_last,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import ndpad_pkg::*;

  localparam int DIW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  cfg_t                  cfg;
  dim_cfg_t              dcfg;
  dim_res_t              res;

  top_state_t            state_r, state_nxt;
  logic [COORD_BITS-1:0] coord_r [MAX_DIMS];
  logic [DIW-1:0]        dim_r, dim_nxt;
  logic [OFS_BITS-1:0]   oacc_r, oacc_nxt, iacc_r, iacc_nxt;
  logic                  fill_r, fill_nxt, last_r, last_nxt, carry_r, carry_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OFS_BITS-1:0]   out_ofs_r, out_ofs_nxt, out_iofs_r, out_iofs_nxt;
  logic                  out_fill_r, out_fill_nxt, out_last_r, out_last_nxt;
  logic [63:0]           out_word_r, out_word_nxt;

  logic [3:0]            nd;
  logic [DIW-1:0]        sel_dim;
  logic                  start;
  logic                  accept;
  logic                  load_out;

  ndpad_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Dimensions in use, clamped to 1..MAX_DIMS
  always_comb begin
    nd = {1'b0, cfg.dims};
    if (nd == 4'd0) begin
      nd = 4'd1;
    end
    if (nd > 4'(MAX_DIMS)) begin
      nd = 4'(MAX_DIMS);
    end
  end

  // Pick the dimension fed to the unit and its settings
  assign sel_dim = (state_r == S_ISSUE) ? dim_r : (dim_r - DIW'(1));
  always_comb begin
    dcfg.mode       = cfg.mode;
    dcfg.in_size    = field16(cfg.in_sizes,    4'(sel_dim));
    dcfg.pad_b      = field16(cfg.pad_before,  4'(sel_dim));
    dcfg.pad_a      = field16(cfg.pad_after,   4'(sel_dim));
    dcfg.in_stride  = field16(cfg.in_strides,  4'(sel_dim));
    dcfg.out_stride = field16(cfg.out_strides, 4'(sel_dim));
  end

  ndpad_dim_unit #(
    .COORD_BITS (COORD_BITS)
  ) u_dim (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .coord (coord_r[sel_dim]),
    .dcfg  (dcfg),
    .res   (res)
  );

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Sequencer over dimensions and output hand-off
  always_comb begin
    state_nxt     = state_r;
    dim_nxt       = dim_r;
    oacc_nxt      = oacc_r;
    iacc_nxt      = iacc_r;
    fill_nxt      = fill_r;
    last_nxt      = last_r;
    carry_nxt     = carry_r;
    start         = 1'b0;
    load_out      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          dim_nxt   = DIW'(nd - 4'd1);
          oacc_nxt  = '0;
          iacc_nxt  = '0;
          fill_nxt  = 1'b0;
          last_nxt  = 1'b1;
          carry_nxt = 1'b1;
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        start     = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (res.done) begin
          // Accumulate this dimension, then start the next slower one
          oacc_nxt = oacc_r + res.oprod;
          iacc_nxt = iacc_r + res.iprod;
          fill_nxt = fill_r | res.fill;
          last_nxt = last_r & res.at_end;
          if (carry_r && !res.at_end) begin
            carry_nxt = 1'b0;
          end
          if (dim_r == '0) begin
            state_nxt = S_OUT;
          end else begin
            start   = 1'b1;
            dim_nxt = dim_r - DIW'(1);
          end
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output register: hold until the result transfer completes
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_ofs_nxt   = out_ofs_r;
    out_iofs_nxt  = out_iofs_r;
    out_fill_nxt  = out_fill_r;
    out_word_nxt  = out_word_r;
    out_last_nxt  = out_last_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_ofs_nxt   = oacc_r;
      out_iofs_nxt  = fill_r ? '0 : iacc_r;
      out_fill_nxt  = fill_r;
      out_word_nxt  = fill_r ? cfg.pad_fill : '0;
      out_last_nxt  = last_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      dim_r       <= '0;
      carry_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      dim_r       <= dim_nxt;
      carry_r     <= carry_nxt;
    end
  end

  // Odometer: clear on restart or unused, step on carry into this dimension
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < MAX_DIMS; d++) begin
        coord_r[d] <= '0;
      end
    end else if (accept) begin
      for (int d = 0; d < MAX_DIMS; d++) begin
        if (in_restart || (4'(d) >= nd)) begin
          coord_r[d] <= '0;
        end
      end
    end else if ((state_r == S_WAIT) && res.done && carry_r) begin
      if (res.at_end) begin
        coord_r[dim_r] <= '0;
      end else begin
        coord_r[dim_r] <= coord_r[dim_r] + COORD_BITS'(1);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    oacc_r     <= oacc_nxt;
    iacc_r     <= iacc_nxt;
    fill_r     <= fill_nxt;
    last_r     <= last_nxt;
    out_ofs_r  <= out_ofs_nxt;
    out_iofs_r <= out_iofs_nxt;
    out_fill_r <= out_fill_nxt;
    out_word_r <= out_word_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_out_offset = out_ofs_r;
  assign out_in_offset  = out_iofs_r;
  assign out_use_fill   = out_fill_r;
  assign out_fill_word  = out_word_r;
  assign out_last       = out_last_r;

  // Busy right after an input transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("input accepted again while an element is in progress");

  // The unit reports only while the sequencer waits for it
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    res.done |-> (state_r == S_WAIT))
    else $error("dimension unit finished outside the wait state");

  // Every dimension is processed before the hand-off
  a_out_after_dim0: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |-> (dim_r == '0))
    else $error("hand-off reached before dimension zero");

  // A filled element carries no source offset
  a_fill_zero_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_use_fill) |-> (out_in_offset == '0))
    else $error("filled element with nonzero source offset");

endmodule
